FILE: rtl/itrd_pkg.sv
// shared constants, types and the digit-to-ascii function for the radix text converter
`default_nettype none

package itrd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;

    // divider retires this many quotient bits per cycle
    localparam int STEP_BITS  = 8;
    localparam int DIV_STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W      = DIV_STEPS * STEP_BITS;
    localparam int STEP_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // digit count holds 0..VALUE_WIDTH, store index 0..VALUE_WIDTH-1
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0]  CH_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CH_A      = 7'h41;
    localparam logic [CHAR_W-1:0]  CH_MINUS  = 7'h2D;
    localparam logic [CHAR_W-1:0]  CH_NONE   = 7'h00;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [RADIX_W-1:0]     radix;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] letter;
        letter = d - DIGIT_TEN;
        if (d <= DIGIT_NINE) begin
            return CH_ZERO + {1'b0, d};
        end
        return CH_A + {1'b0, letter};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/itrd_divider.sv
// iterative divider by a small radix: eight quotient bits per cycle, remainder and quotient out
`default_nettype none

module itrd_divider
    import itrd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_step;
    logic [DIV_W-1:0]      r_work;
    logic [DIGIT_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_radix;

    logic [DIV_W-1:0]      n_work;
    logic [DIGIT_W-1:0]    n_rem;

    // restoring steps; the partial remainder stays below the radix
    always_comb begin
        logic [DIGIT_W:0] trial;
        logic [DIGIT_W:0] diff;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < STEP_BITS; k++) begin
            trial  = {n_rem, n_work[DIV_W-1]};
            diff   = trial - {1'b0, r_radix};
            n_work = {n_work[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_radix}) begin
                n_rem     = diff[DIGIT_W-1:0];
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work  <= DIV_W'(i_req.dividend);
            r_rem   <= '0;
            r_radix <= i_req.radix;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_work[VALUE_WIDTH-1:0];
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

FILE: rtl/integer_to_radix_digits_unit.sv
// signed integer to radix 2..36 ascii text: sequencer, digit store and output register
//
// Input channel: i_valid / o_stall carry i_value (signed) and i_radix. An item is
// taken when i_valid is high and o_stall is low; o_stall stays high from the
// accepting edge until the last character of that item has been loaded into the
// output register.
// Output channel: o_valid / i_stall carry o_character, o_last and o_bad_radix,
// one character per beat, most significant digit first, a leading '-' for
// negative values, o_last on the final character.
// Each digit is one pass through the shared divider.
// A radix outside 2..36 gives a single beat with o_bad_radix and o_last set and
// character zero, loaded into the output register from the emit state.
// The output register lets the next character load in the cycle the current one
// is taken; while i_stall is high the emitter holds and the payload is stable.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
`default_nettype none

module integer_to_radix_digits_unit
    import itrd_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    input  wire logic        [RADIX_W-1:0]     i_radix,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic             [CHAR_W-1:0]      o_character,
    output logic                               o_last,
    output logic                               o_bad_radix
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_neg, n_neg;
    logic               r_bad, n_bad;
    logic               r_out_valid, n_out_valid;
    logic [RADIX_W-1:0] r_radix, n_radix;

    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_bad_out;

    logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic                   in_accept;
    logic                   radix_ok;
    logic                   out_free;
    logic                   emit_en;
    logic                   digit_wr;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [CNT_W-1:0]       count_m1;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign radix_ok  = i_radix inside {[RADIX_MIN:RADIX_MAX]};
    assign out_free  = !r_out_valid || !i_stall;
    assign emit_en   = (r_state == S_EMIT) && out_free;
    assign digit_wr  = (r_state == S_DIV) && div_rsp.done;
    assign count_m1  = r_count - 1'b1;

    // two's complement magnitude, exact for the most negative value
    assign magnitude = i_value[VALUE_WIDTH-1] ? (~$unsigned(i_value) + 1'b1)
                                              : $unsigned(i_value);

    always_comb begin
        div_req.start    = (in_accept && radix_ok) ||
                           (digit_wr && (div_rsp.quotient != '0));
        div_req.dividend = (r_state == S_IDLE) ? magnitude : div_rsp.quotient;
        div_req.radix    = (r_state == S_IDLE) ? i_radix : r_radix;
    end

    itrd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_neg       = r_neg;
        n_bad       = r_bad;
        n_radix     = r_radix;
        n_out_valid = r_out_valid;
        if (emit_en) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (!radix_ok) begin
                        n_bad   = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_bad   = 1'b0;
                        n_neg   = i_value[VALUE_WIDTH-1];
                        n_count = '0;
                        n_radix = i_radix;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_count = r_count + 1'b1;
                    if (div_rsp.quotient == '0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_bad) begin
                        n_state = S_IDLE;
                    end else if (r_neg) begin
                        n_neg = 1'b0;
                    end else begin
                        n_count = count_m1;
                        if (r_count == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_neg       <= n_neg;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    // digit store (least significant first) and output payload
    always_ff @(posedge i_clk) begin
        r_radix <= n_radix;
        if (digit_wr) begin
            digit_mem[r_count[IDX_W-1:0]] <= div_rsp.remainder;
        end
        if (emit_en) begin
            if (r_bad) begin
                r_char    <= CH_NONE;
                r_last    <= 1'b1;
                r_bad_out <= 1'b1;
            end else if (r_neg) begin
                r_char    <= CH_MINUS;
                r_last    <= 1'b0;
                r_bad_out <= 1'b0;
            end else begin
                r_char    <= digit_to_ascii(digit_mem[count_m1[IDX_W-1:0]]);
                r_last    <= (r_count == CNT_W'(1));
                r_bad_out <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad_out;

    // a bad-radix beat is always a lone, empty final character
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_radix) |-> (o_last && (o_character == CH_NONE)))
        else $error("bad radix beat without last or with a character");

    // divider results only arrive while the sequencer is dividing
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    // the digit count never exceeds the store depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VALUE_WIDTH))
        else $error("digit count beyond store depth");

    // leaving emit means the final character has just been loaded
    a_last_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && (n_state == S_IDLE)) |=> (o_valid && o_last))
        else $error("conversion ended without a last character");

endmodule

`default_nettype wire
